@@ design/bssa_pkg.sv @@
// Shared constants for the bitmap stack slot allocator: sizes, request kinds,
// status codes and configuration register indexes.
// No dependencies; imported by bssa_ram users and the top level.
package bssa_pkg;

    localparam int MAX_SLOTS  = 256;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_IDX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SLOT_IDX_W = WORD_IDX_W + BIT_IDX_W;

    localparam int ADDR_W      = 64;
    localparam int SHIFT_W     = 6;
    localparam int COUNT_W     = 9;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CLAIM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_BASE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT     = 2'd2;

    // reset values of the configuration registers
    localparam logic [ADDR_W-1:0]  RST_REGION_BASE    = '0;
    localparam logic [SHIFT_W-1:0] RST_SLOT_SIZE_LOG2 = 6'd12;
    localparam logic [COUNT_W-1:0] RST_SLOT_COUNT     = 9'd256;

endpackage

@@ design/bssa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bssa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bitmap_stack_slot_allocator_unit.sv @@
// Top level of the bitmap stack slot allocator: request sequencer, configuration
// registers and the used-bit bitmap held in a bssa_ram instance.
// Depends on bssa_pkg and bssa_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request per transaction:
//   i_kind selects claim-at-address, find-first-free or release, i_address is
//   the stack address (ignored for find). The output channel (o_out_valid /
//   i_out_ready) returns exactly one transaction per request: o_slot_address
//   and o_status (ok, out of range, none free).
//   A request that fails the range check or has an unknown kind passes the
//   address and index states and goes straight to finish; claim and release
//   also read and modify the target word, and find scans from 1 to NUM_WORDS
//   (4 by default) bitmap words. The scan reads one bitmap word per cycle
//   through the single read port of the bitmap RAM, which sets the find time.
//   One request is in work at a time; the next can be taken in the cycle after
//   the previous result enters the output register.
//   Reset clears all used bits at once through per-word valid flags (a word
//   never written reads as all free) and loads the register defaults.
//   Configuration writes (i_cfg_wr_en) take effect at once and are expected
//   while the block is idle. A stalled receiver holds the result in the output
//   register; a further finished result waits until that one is taken.
module bitmap_stack_slot_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [bssa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bssa_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bssa_pkg::KIND_W-1:0]         i_kind,
    input  logic [bssa_pkg::ADDR_W-1:0]         i_address,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bssa_pkg::ADDR_W-1:0]         o_slot_address,
    output logic [bssa_pkg::STATUS_W-1:0]       o_status
);

    import bssa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CALC   = 7'b0000010,
        S_INDEX  = 7'b0000100,
        S_READ   = 7'b0001000,
        S_MODIFY = 7'b0010000,
        S_SEARCH = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

    // configuration registers
    logic [ADDR_W-1:0]  r_region_base;
    logic [SHIFT_W-1:0] r_slot_size_log2;
    logic [COUNT_W-1:0] r_slot_count;

    // request context
    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind;
    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      r_sel;
    logic [ADDR_W-1:0]      r_diff;
    logic                   r_below;
    logic [SLOT_IDX_W-1:0]  r_idx;
    logic [WORD_IDX_W-1:0]  r_word;
    logic [STATUS_W-1:0]    r_status;

    // bitmap word valid flags (a word never written reads as all free)
    logic [NUM_WORDS-1:0]   r_word_valid;
    logic                   r_rd_valid;

    // output register
    logic                   r_out_valid;
    logic [ADDR_W-1:0]      r_out_addr;
    logic [STATUS_W-1:0]    r_out_status;

    // combinational
    logic                   in_accept;
    logic                   out_load;
    logic [COUNT_W-1:0]     eff_count;
    logic [ADDR_W-1:0]      align_mask;
    logic [ADDR_W-1:0]      sel_addr;
    logic [ADDR_W:0]        diff_ext;
    logic [ADDR_W-1:0]      slot_off;
    logic                   in_range;
    logic [WORD_IDX_W-1:0]  ram_rd_addr;
    logic [WORD_BITS-1:0]   ram_q;
    logic [WORD_BITS-1:0]   rd_word;
    logic                   ram_we;
    logic [WORD_IDX_W-1:0]  ram_wr_addr;
    logic [WORD_BITS-1:0]   ram_wr_data;
    logic [WORD_BITS-1:0]   bit_sel;
    logic [WORD_BITS-1:0]   free_bits;
    logic                   found;
    logic [BIT_IDX_W-1:0]   found_bit;
    logic [ADDR_W-1:0]      res_addr;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    // saturate the slot count to the bitmap size
    assign eff_count = (r_slot_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                             : r_slot_count;

    // claim aligns down to the slot size; release uses the raw address
    assign align_mask = {ADDR_W{1'b1}} << r_slot_size_log2;
    assign sel_addr   = (r_kind == KIND_CLAIM) ? (r_addr & align_mask) : r_addr;
    assign diff_ext   = {1'b0, sel_addr} - {1'b0, r_region_base};

    // slot index and range check on the registered difference
    assign slot_off = r_diff >> r_slot_size_log2;
    assign in_range = !r_below && (slot_off < ADDR_W'(eff_count));

    // bitmap read address: the target word, or the next word of a scan
    always_comb begin
        ram_rd_addr = r_word;
        if (r_state == S_SEARCH) begin
            ram_rd_addr = r_word + WORD_IDX_W'(1);
        end else if (r_kind != KIND_FIND) begin
            ram_rd_addr = r_idx[SLOT_IDX_W-1:BIT_IDX_W];
        end
    end

    assign rd_word = r_rd_valid ? ram_q : '0;
    assign bit_sel = WORD_BITS'(1) << r_idx[BIT_IDX_W-1:0];

    // free bits of the scanned word, limited to slots below the count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            free_bits[b] = !rd_word[b] &&
                ((COUNT_W'(r_word) << BIT_IDX_W) + COUNT_W'(b) < eff_count);
        end
    end

    // lowest free bit
    always_comb begin
        found_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found_bit = BIT_IDX_W'(b);
            end
        end
    end
    assign found = |free_bits;

    // write back: set or clear the target bit, or mark the found slot used
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = r_idx[SLOT_IDX_W-1:BIT_IDX_W];
        ram_wr_data = rd_word | bit_sel;
        if (r_state == S_MODIFY) begin
            ram_we = 1'b1;
            if (r_kind == KIND_RELEASE) begin
                ram_wr_data = rd_word & ~bit_sel;
            end
        end else if (r_state == S_SEARCH && found) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_word;
            ram_wr_data = rd_word | (WORD_BITS'(1) << found_bit);
        end
    end

    bssa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    // result address: aligned address for claim, slot start otherwise
    always_comb begin
        if (r_status != ST_OK) begin
            res_addr = '0;
        end else if (r_kind == KIND_CLAIM) begin
            res_addr = r_sel;
        end else begin
            res_addr = r_region_base + (ADDR_W'(r_idx) << r_slot_size_log2);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_accept) n_state = S_CALC;
            S_CALC:   n_state = S_INDEX;
            S_INDEX: begin
                if (r_kind == KIND_FIND) begin
                    n_state = S_READ;
                end else if ((r_kind == KIND_CLAIM || r_kind == KIND_RELEASE) && in_range) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_READ:   n_state = (r_kind == KIND_FIND) ? S_SEARCH : S_MODIFY;
            S_MODIFY: n_state = S_FINISH;
            S_SEARCH: if (found || r_word == LAST_WORD) n_state = S_FINISH;
            S_FINISH: if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_region_base    <= RST_REGION_BASE;
            r_slot_size_log2 <= RST_SLOT_SIZE_LOG2;
            r_slot_count     <= RST_SLOT_COUNT;
            r_word_valid     <= '0;
            r_rd_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= r_word_valid[ram_rd_addr];
            if (ram_we) begin
                r_word_valid[ram_wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_REGION_BASE:    r_region_base    <= i_cfg_wr_data;
                    CFG_SLOT_SIZE_LOG2: r_slot_size_log2 <= i_cfg_wr_data[SHIFT_W-1:0];
                    CFG_SLOT_COUNT:     r_slot_count     <= i_cfg_wr_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_kind;
            r_addr <= i_address;
        end
        if (r_state == S_CALC) begin
            r_sel   <= sel_addr;
            r_diff  <= diff_ext[ADDR_W-1:0];
            r_below <= diff_ext[ADDR_W];
        end
        if (r_state == S_INDEX) begin
            r_idx    <= slot_off[SLOT_IDX_W-1:0];
            r_word   <= '0;
            r_status <= (r_kind == KIND_FIND) ? ST_NONE : ST_RANGE;
            if ((r_kind == KIND_CLAIM || r_kind == KIND_RELEASE) && in_range) begin
                r_status <= ST_OK;
            end
        end
        if (r_state == S_SEARCH) begin
            if (found) begin
                r_idx    <= {r_word, found_bit};
                r_status <= ST_OK;
            end else if (r_word != LAST_WORD) begin
                r_word <= r_word + WORD_IDX_W'(1);
            end
        end
        if (out_load) begin
            r_out_addr   <= res_addr;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_slot_address = r_out_addr;
    assign o_status       = r_out_status;

    // failed requests report address zero
    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_slot_address == '0))
        else $error("error result with nonzero slot address");

    // the bitmap is written only while modifying or scanning
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_MODIFY || r_state == S_SEARCH))
        else $error("bitmap write outside modify or scan");

    // an accepted request always starts at the address stage
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CALC))
        else $error("accepted request did not enter address stage");

    // a held result is not overwritten while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_slot_address)
                                           && $stable(o_status)))
        else $error("stalled result changed");

endmodule

@@ bench/bssa_checker.sv @@
// Checker for the bitmap stack slot allocator: tracks configuration writes,
// predicts each result from its own copy of the used-slot map and compares.
// Depends on bssa_pkg.
module bssa_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [bssa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bssa_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [bssa_pkg::KIND_W-1:0]         i_kind,
    input  logic [bssa_pkg::ADDR_W-1:0]         i_address,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [bssa_pkg::ADDR_W-1:0]         i_slot_address,
    input  logic [bssa_pkg::STATUS_W-1:0]       i_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bssa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
    } t_slot_outcome;

    t_slot_outcome          pending_outcomes[$];
    t_slot_outcome          want;
    logic [ADDR_W-1:0]      region_base;
    logic [SHIFT_W-1:0]     size_log2;
    logic [COUNT_W-1:0]     slot_count;
    logic [MAX_SLOTS-1:0]   used_map;

    function automatic int unsigned live_slots();
        return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
    endfunction

    // Map an address to its slot; false when it falls outside the region.
    function automatic bit slot_index_of(input logic [ADDR_W-1:0] addr,
                                         output int unsigned idx);
        logic [ADDR_W-1:0] offs;
        idx = 0;
        if (addr < region_base)
            return 1'b0;
        offs = (addr - region_base) >> size_log2;
        if (offs >= live_slots())
            return 1'b0;
        idx = offs[31:0];
        return 1'b1;
    endfunction

    // Work out the result of one request and update the used-slot map.
    function automatic t_slot_outcome allocation_outcome(input logic [KIND_W-1:0] kind,
                                                         input logic [ADDR_W-1:0] addr);
        t_slot_outcome     res;
        logic [ADDR_W-1:0] aligned;
        int unsigned       idx;
        res.slot_address = '0;
        res.status       = ST_RANGE;
        case (kind)
            KIND_CLAIM: begin
                aligned = addr & ~((64'd1 << size_log2) - 64'd1);
                if (slot_index_of(aligned, idx)) begin
                    used_map[idx]    = 1'b1;
                    res.slot_address = aligned;
                    res.status       = ST_OK;
                end
            end
            KIND_FIND: begin
                res.status = ST_NONE;
                for (int i = 0; i < live_slots(); i++) begin
                    if (!used_map[i]) begin
                        used_map[i]      = 1'b1;
                        res.slot_address = region_base + (64'(i) << size_log2);
                        res.status       = ST_OK;
                        break;
                    end
                end
            end
            KIND_RELEASE: begin
                if (slot_index_of(addr, idx)) begin
                    used_map[idx]    = 1'b0;
                    res.slot_address = region_base + (64'(idx) << size_log2);
                    res.status       = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            region_base  = RST_REGION_BASE;
            size_log2    = RST_SLOT_SIZE_LOG2;
            slot_count   = RST_SLOT_COUNT;
            used_map     = '0;
            o_fail_count = 0;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_REGION_BASE:    region_base = i_cfg_wr_data;
                    CFG_SLOT_SIZE_LOG2: size_log2   = i_cfg_wr_data[SHIFT_W-1:0];
                    CFG_SLOT_COUNT:     slot_count  = i_cfg_wr_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest outcome before queuing a new one
            if (i_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("unexpected result: slot_address %h status %0d",
                           i_slot_address, i_status);
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_slot_address !== want.slot_address) begin
                        $error("slot_address: expected %h, got %h",
                               want.slot_address, i_slot_address);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pending_outcomes.push_back(allocation_outcome(i_kind, i_address));
        end
        o_pending = pending_outcomes.size();
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the allocator testbench: clock, reset, request and result traffic,
// register writes, watchdog and final verdict.
// Depends on bssa_pkg, bitmap_stack_slot_allocator_unit and bssa_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bssa_pkg::*;

    localparam int LIMIT     = 2000;   // cycles without any transaction
    localparam int TAIL      = 20;     // settle time after the last result
    localparam int SETTLE    = 6;      // idle cycles before a register write
    localparam logic [KIND_W-1:0]      KIND_UNKNOWN = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE    = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      in_kind;
    logic [ADDR_W-1:0]      in_address;
    logic                   o_out_valid;
    logic                   out_ready;
    logic [ADDR_W-1:0]      o_slot_address;
    logic [STATUS_W-1:0]    o_status;
    int                     fail_count;
    int                     pending;
    int                     quiet_cycles;

    // stimulus-side view of the configuration, used only to aim addresses
    logic [ADDR_W-1:0]      cur_base;
    logic [SHIFT_W-1:0]     cur_log2;
    logic [COUNT_W-1:0]     cur_count;
    bit                     no_idle;

    bitmap_stack_slot_allocator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (in_kind),
        .i_address      (in_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_slot_address (o_slot_address),
        .o_status       (o_status)
    );

    bssa_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (o_in_ready),
        .i_kind         (in_kind),
        .i_address      (in_address),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .i_slot_address (o_slot_address),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Draw the per-transaction wait; zero throughout a burst phase.
    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Aim most addresses at slots of the current region (a couple past its
    // end included), some just below the base and some anywhere at all.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] mask;
        int unsigned       live;
        live = (cur_count > MAX_SLOTS) ? MAX_SLOTS : int'(cur_count);
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return cur_base - 64'($urandom_range(1, 4096));
            default: begin
                idx  = 64'($urandom_range(0, live + 1));
                mask = (64'd1 << cur_log2) - 64'd1;
                return cur_base + (idx << cur_log2) + ({$urandom, $urandom} & mask);
            end
        endcase
    endfunction

    // Present one request and hold it until the transaction completes.
    // Valid stays high straight into the next request when no gap is drawn.
    task automatic send(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_kind    <= kind;
        in_address <= addr;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding result has been taken.
    task automatic wait_until_settled();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge i_clk);
    endtask

    // Reprogram the region while the block is idle. Upper data bits carry
    // noise to show that only the register's own width is kept, and the
    // unused index gets a write that must change nothing.
    task automatic configure(input logic [ADDR_W-1:0] base,
                             input logic [SHIFT_W-1:0] log2,
                             input logic [COUNT_W-1:0] count);
        logic [CFG_DATA_W-1:0] noise;
        noise = {$urandom, $urandom};
        wait_until_settled();
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_SLOT_SIZE_LOG2, {noise[CFG_DATA_W-1:SHIFT_W], log2});
        write_reg(CFG_SLOT_COUNT, {noise[CFG_DATA_W-1:COUNT_W], count});
        write_reg(CFG_SPARE, ~noise);
        cfg_wr_en <= 1'b0;
        cur_base  = base;
        cur_log2  = log2;
        cur_count = count;
    endtask

    task automatic random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send(KIND_FIND, {$urandom, $urandom});
        else if (pick < 70)
            send(KIND_CLAIM, pick_address());
        else if (pick < 96)
            send(KIND_RELEASE, pick_address());
        else
            send(KIND_UNKNOWN, pick_address());
    endtask

    // One phase: fresh region, then a mix of finds, claims, releases and unknown kinds.
    // Small counts dominate so that the region fills and drains often.
    task automatic random_phase(input int n);
        logic [ADDR_W-1:0]  base;
        logic [SHIFT_W-1:0] log2;
        logic [COUNT_W-1:0] count;
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = {$urandom, $urandom};
            2: base = ~64'($urandom_range(0, 1 << 20));
            default: base = 64'($urandom) << 12;
        endcase
        if ($urandom_range(0, 4) != 0)
            log2 = SHIFT_W'($urandom_range(4, 32));
        else
            log2 = SHIFT_W'($urandom_range(0, 63));
        case ($urandom_range(0, 9))
            0: count = ($urandom_range(0, 1) != 0) ? '0 : COUNT_W'($urandom_range(256, 511));
            1, 2: count = COUNT_W'($urandom_range(25, 300));
            default: count = COUNT_W'($urandom_range(1, 24));
        endcase
        configure(base, log2, count);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            // now and then let the pipeline run dry mid-phase
            if (i == n / 2 && $urandom_range(0, 1) != 0)
                wait_until_settled();
            random_request();
        end
    endtask

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stall for a drawn number of cycles, then take the result.
    initial begin
        int unsigned stall;
        out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_REGION_BASE;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        in_kind      = KIND_CLAIM;
        in_address   = '0;
        no_idle      = 1'b0;
        cur_base     = RST_REGION_BASE;
        cur_log2     = RST_SLOT_SIZE_LOG2;
        cur_count    = RST_SLOT_COUNT;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset region: 4 KiB slots from address 0, full count.
        send(KIND_FIND, '0);                      // lowest slot first
        send(KIND_FIND, '1);                      // address is ignored by find
        send(KIND_CLAIM, 64'h2fff);               // aligns down to 0x2000
        send(KIND_CLAIM, 64'h2000);               // claim of a used slot
        send(KIND_FIND, '0);                      // skips the claimed slot
        send(KIND_RELEASE, 64'h1234);             // release uses the raw address
        send(KIND_RELEASE, 64'h1000);             // release of a free slot
        send(KIND_FIND, '0);                      // reuses the hole
        send(KIND_CLAIM, 64'h10_0000);            // first slot past the end
        send(KIND_CLAIM, '1);
        send(KIND_RELEASE, '1);
        send(KIND_CLAIM, 64'hf_ffff);             // top slot of the region
        send(KIND_RELEASE, 64'hf_f000);
        send(KIND_UNKNOWN, '1);                   // unknown kind
        send(KIND_UNKNOWN, '0);

        // Tiny region above 4 GiB: fill it, run out, free one, refill.
        configure(64'h1_0000_0000, 6'd4, 9'd3);
        send(KIND_CLAIM, 64'hffff_fff0);          // just below the base
        send(KIND_FIND, '0);
        send(KIND_FIND, '0);
        send(KIND_FIND, '0);
        send(KIND_FIND, '0);                      // nothing free
        send(KIND_RELEASE, '0);
        send(KIND_RELEASE, 64'h1_0000_002f);
        send(KIND_FIND, '0);

        // Empty region: everything is out of range or none free.
        configure(64'h1_0000_0000, 6'd4, 9'd0);
        send(KIND_FIND, '0);
        send(KIND_CLAIM, 64'h1_0000_0000);
        send(KIND_RELEASE, 64'h1_0000_0000);

        // Region that wraps past the top of the address space: fill across
        // bitmap word boundaries until none are left, then free and refill.
        configure(64'hffff_ffff_ffff_fc00, 6'd4, 9'd130);
        no_idle = 1'b1;
        repeat (132) send(KIND_FIND, {$urandom, $urandom});
        no_idle = 1'b0;
        repeat (8) send(KIND_RELEASE, pick_address());
        repeat (8) send(KIND_FIND, '0);

        // Size and count extremes.
        configure('0, 6'd0, 9'd511);              // byte slots, count saturates
        repeat (30) random_request();
        configure({$urandom, $urandom}, 6'd63, 9'd2);
        repeat (30) random_request();
        configure('1, 6'd32, 9'd256);
        repeat (30) random_request();
        configure(64'h8000_0000_0000_0000, 6'd32, 9'd257);
        repeat (30) random_request();

        repeat (12) random_phase(40);

        wait_until_settled();
        repeat (TAIL) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ bitmap_stack_slot_allocator_unit.f @@
design/bssa_pkg.sv
design/bssa_ram.sv
design/bitmap_stack_slot_allocator_unit.sv
bench/bssa_checker.sv
bench/tb_top.sv
